// ----- design/scsa_pkg.sv -----
// Shared types and constants for the size-class slab allocator.
// No dependencies.
package scsa_pkg;

  localparam int SLOT_W    = 6;
  localparam int FRAME_W   = 6;
  localparam int HANDLE_W  = FRAME_W + SLOT_W;
  localparam int LINK_W    = HANDLE_W + 1;
  localparam int CLASS_W   = 4;
  localparam int UCNT_W    = 7;
  localparam int FRAMES    = 64;
  localparam int CLASSES   = 16;
  localparam int SLOTS     = 64;
  localparam int MAX_EXP   = 23;
  localparam int BYTES_W   = 24;
  localparam int USAGE_W   = 36;
  localparam int CNT_W     = 32;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO      = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_NO_FRAME  = 3'd3;
  localparam logic [2:0] ST_NOT_OWNED = 3'd4;

  localparam logic CFG_SHIFT = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  typedef struct packed {
    logic               own_we;
    logic               cnt_we;
    logic [FRAME_W-1:0] addr;
    logic [CLASS_W-1:0] owner;
    logic [UCNT_W-1:0]  cnt;
  } frm_wr_t;

  function automatic logic [BYTES_W-1:0] class_bytes(input logic [4:0] e);
    logic [4:0] c;
    c = (e > 5'(MAX_EXP)) ? 5'(MAX_EXP) : e;
    return BYTES_W'(1) << c;
  endfunction

endpackage

// ----- design/scsa_link_ram.sv -----
// Free-list link memory: one link per slot handle.
// Depends on scsa_pkg.
module scsa_link_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [scsa_pkg::HANDLE_W-1:0] waddr,
  input  logic [scsa_pkg::LINK_W-1:0]   wdata,
  input  logic [scsa_pkg::HANDLE_W-1:0] raddr,
  output logic [scsa_pkg::LINK_W-1:0]   rdata
);

  logic [scsa_pkg::LINK_W-1:0] mem [scsa_pkg::FRAMES*scsa_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/scsa_frame_table.sv -----
// Per-frame owner class and use count memories.
// Depends on scsa_pkg (frm_wr_t).
module scsa_frame_table (
  input  logic                         clk,
  input  scsa_pkg::frm_wr_t            wr,
  input  logic [scsa_pkg::FRAME_W-1:0] raddr,
  output logic [scsa_pkg::CLASS_W-1:0] owner_rd,
  output logic [scsa_pkg::UCNT_W-1:0]  cnt_rd
);

  logic [scsa_pkg::CLASS_W-1:0] owner_mem [scsa_pkg::FRAMES];
  logic [scsa_pkg::UCNT_W-1:0]  cnt_mem   [scsa_pkg::FRAMES];

  always_ff @(posedge clk) begin
    if (wr.own_we) begin
      owner_mem[wr.addr] <= wr.owner;
    end
    if (wr.cnt_we) begin
      cnt_mem[wr.addr] <= wr.cnt;
    end
    owner_rd <= owner_mem[raddr];
    cnt_rd   <= cnt_mem[raddr];
  end

endmodule

// ----- design/size_class_slab_allocator_core.sv -----
// Size-class slab allocator top level: sequencer, list heads, statistics.
// Depends on scsa_pkg, scsa_link_ram, scsa_frame_table.
//
//  channel | ports                                  | handshake
//  input   | in_action, in_request_bytes,           | start & !busy
//          | in_slab_frame, in_slot_index           |
//  result  | out_status .. out_fail_total           | out_valid, one cycle
//  config  | cfg_index, cfg_data                    | cfg_valid & cfg_ready
//
// Heads and memories are read in the accept cycle, and the link/frame memories
// are updated and the result registered in the next.
// An allocate that opens a fresh frame walks its slots, one link write each.
// After reset busy stays high while the initial walk links frames 0 to 8.
// Results cannot be stalled; a new item may start while a result is shown.
module size_class_slab_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [23:0] in_request_bytes,
  input  logic [5:0]  in_slab_frame,
  input  logic [5:0]  in_slot_index,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [5:0]  out_granted_frame,
  output logic [5:0]  out_granted_slot,
  output logic [3:0]  out_size_class,
  output logic [23:0] out_granted_bytes,
  output logic [35:0] out_usage_bytes,
  output logic [31:0] out_alloc_total,
  output logic [31:0] out_free_total,
  output logic [31:0] out_fail_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INIT = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_WALK = 2'd3;
  localparam int         VB     = scsa_pkg::HANDLE_W;
  localparam logic [3:0] INIT_LAST = 4'd8;

  logic [1:0]  state_r, state_nxt;
  logic [3:0]  shift_r;
  logic [4:0]  ccount_r;
  logic [12:0] head_r [scsa_pkg::CLASSES];
  logic [6:0]  taken_r;
  logic [35:0] usage_r;
  logic [31:0] alloc_r, free_r, fail_r;
  logic        op_r, zero_r, found_r;
  logic [3:0]  cls_r;
  logic [12:0] hd_r;
  logic [5:0]  frame_r, slot_r, fr_r, walk_r;
  logic [3:0]  init_r;

  logic        out_valid_r;
  logic [2:0]  status_r;
  logic [5:0]  gframe_r, gslot_r;
  logic [3:0]  ocls_r;
  logic [23:0] gbytes_r;

  logic [4:0]  n_use;
  logic        rt_found;
  logic [3:0]  rt_k;
  logic [12:0] link_rd;
  logic        link_we;
  logic [11:0] link_waddr;
  logic [12:0] link_wdata;
  logic [3:0]  owner_rd;
  logic [6:0]  cnt_rd;
  logic [5:0]  frm_raddr;
  scsa_pkg::frm_wr_t frm_wr;
  logic        accept;
  logic [23:0] cls_bytes, own_bytes;
  logic [36:0] usage_sum;
  logic        own_ok;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy && !start;
  assign n_use     = (ccount_r > 5'(scsa_pkg::CLASSES)) ? 5'(scsa_pkg::CLASSES) : ccount_r;

  always_comb begin
    rt_found = 1'b0;
    rt_k     = '0;
    for (int k = scsa_pkg::CLASSES - 1; k >= 0; k--) begin
      if ((5'(k) < n_use) && (5'(shift_r) + 5'(k) <= 5'(scsa_pkg::MAX_EXP)) &&
          (in_request_bytes <= (24'd1 << (5'(shift_r) + 5'(k))))) begin
        rt_found = 1'b1;
        rt_k     = 4'(k);
      end
    end
  end

  assign frm_raddr = in_action ? in_slab_frame : head_r[rt_k][11:6];
  assign cls_bytes = scsa_pkg::class_bytes(5'(shift_r) + 5'(cls_r));
  assign own_bytes = scsa_pkg::class_bytes(5'(shift_r) + 5'(owner_rd));
  assign usage_sum = {1'b0, usage_r} + 37'(cls_bytes);
  assign own_ok    = ({1'b0, frame_r} < taken_r);

  scsa_link_ram u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (head_r[rt_k][11:0]),
    .rdata (link_rd)
  );

  scsa_frame_table u_frm (
    .clk      (clk),
    .wr       (frm_wr),
    .raddr    (frm_raddr),
    .owner_rd (owner_rd),
    .cnt_rd   (cnt_rd)
  );

  always_comb begin
    state_nxt  = state_r;
    link_we    = 1'b0;
    link_waddr = {fr_r, walk_r};
    link_wdata = (walk_r == '0) ? hd_r : {1'b1, fr_r, walk_r - 6'd1};
    frm_wr     = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_INIT: begin
        link_we    = 1'b1;
        link_waddr = {2'b00, init_r, walk_r};
        link_wdata = (walk_r == '0) ? 13'd0 : {1'b1, 2'b00, init_r, walk_r - 6'd1};
        if (walk_r == '0) begin
          frm_wr.own_we = 1'b1;
          frm_wr.cnt_we = 1'b1;
          frm_wr.addr   = {2'b00, init_r};
          frm_wr.owner  = init_r;
        end
        if (walk_r == '1 && init_r == INIT_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (!op_r) begin
          if (!zero_r && found_r) begin
            if (hd_r[VB]) begin
              frm_wr.cnt_we = 1'b1;
              frm_wr.addr   = hd_r[11:6];
              frm_wr.cnt    = (cnt_rd == '1) ? cnt_rd : cnt_rd + 7'd1;
            end else if (taken_r < 7'(scsa_pkg::FRAMES)) begin
              frm_wr.own_we = 1'b1;
              frm_wr.addr   = taken_r[5:0];
              frm_wr.owner  = cls_r;
              state_nxt     = S_WALK;
            end
          end
        end else if (own_ok) begin
          link_we       = 1'b1;
          link_waddr    = {frame_r, slot_r};
          link_wdata    = head_r[owner_rd];
          frm_wr.cnt_we = 1'b1;
          frm_wr.addr   = frame_r;
          frm_wr.cnt    = (cnt_rd == '0) ? cnt_rd : cnt_rd - 7'd1;
        end
      end
      S_WALK: begin
        link_we = 1'b1;
        if (walk_r == '1) begin
          frm_wr.cnt_we = 1'b1;
          frm_wr.addr   = fr_r;
          frm_wr.cnt    = 7'd1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      shift_r     <= 4'd4;
      ccount_r    <= 5'd9;
      taken_r     <= '0;
      usage_r     <= '0;
      alloc_r     <= '0;
      free_r      <= '0;
      fail_r      <= '0;
      walk_r      <= '0;
      init_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < scsa_pkg::CLASSES; i++) begin
        head_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == scsa_pkg::CFG_SHIFT) begin
          shift_r <= cfg_data[3:0];
        end else begin
          ccount_r <= cfg_data;
        end
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_action;
            zero_r  <= (in_request_bytes == '0);
            found_r <= rt_found;
            cls_r   <= rt_k;
            hd_r    <= head_r[rt_k];
            frame_r <= in_slab_frame;
            slot_r  <= in_slot_index;
          end
        end
        S_INIT: begin
          walk_r <= walk_r + 6'd1;
          if (walk_r == '1) begin
            head_r[init_r] <= {1'b1, 2'b00, init_r, 6'h3f};
            init_r         <= init_r + 4'd1;
            taken_r        <= 7'(init_r) + 7'd1;
          end
        end
        S_EXEC: begin
          out_valid_r <= (state_nxt == S_IDLE);
          status_r    <= scsa_pkg::ST_OK;
          gframe_r    <= '0;
          gslot_r     <= '0;
          ocls_r      <= '0;
          gbytes_r    <= '0;
          if (!op_r) begin
            if (zero_r) begin
              status_r <= scsa_pkg::ST_ZERO;
            end else if (!found_r) begin
              status_r <= scsa_pkg::ST_TOO_LARGE;
              if (fail_r != '1) fail_r <= fail_r + 32'd1;
            end else begin
              ocls_r   <= cls_r;
              gbytes_r <= cls_bytes;
              if (hd_r[VB]) begin
                head_r[cls_r] <= link_rd;
                gframe_r      <= hd_r[11:6];
                gslot_r       <= hd_r[5:0];
                usage_r       <= usage_sum[36] ? '1 : usage_sum[35:0];
                if (alloc_r != '1) alloc_r <= alloc_r + 32'd1;
              end else if (taken_r < 7'(scsa_pkg::FRAMES)) begin
                fr_r    <= taken_r[5:0];
                taken_r <= taken_r + 7'd1;
                walk_r  <= '0;
              end else begin
                status_r <= scsa_pkg::ST_NO_FRAME;
                if (fail_r != '1) fail_r <= fail_r + 32'd1;
              end
            end
          end else if (own_ok) begin
            head_r[owner_rd] <= {1'b1, frame_r, slot_r};
            ocls_r           <= owner_rd;
            gbytes_r         <= own_bytes;
            gframe_r         <= frame_r;
            gslot_r          <= slot_r;
            usage_r          <= (usage_r > 36'(own_bytes)) ? usage_r - 36'(own_bytes) : '0;
            if (free_r != '1) free_r <= free_r + 32'd1;
          end else begin
            status_r <= scsa_pkg::ST_NOT_OWNED;
          end
        end
        S_WALK: begin
          walk_r <= walk_r + 6'd1;
          if (walk_r == '1) begin
            head_r[cls_r] <= {1'b1, fr_r, 6'h3e};
            out_valid_r   <= 1'b1;
            gframe_r      <= fr_r;
            gslot_r       <= 6'h3f;
            usage_r       <= usage_sum[36] ? '1 : usage_sum[35:0];
            if (alloc_r != '1) alloc_r <= alloc_r + 32'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_granted_frame = gframe_r;
  assign out_granted_slot  = gslot_r;
  assign out_size_class    = ocls_r;
  assign out_granted_bytes = gbytes_r;
  assign out_usage_bytes   = usage_r;
  assign out_alloc_total   = alloc_r;
  assign out_free_total    = free_r;
  assign out_fail_total    = fail_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_EXEC))
    else $error("accepted item did not enter execute");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_EXEC || $past(state_r) == S_WALK))
    else $error("result strobe without finishing item");

  a_walk_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_WALK) |-> ($past(state_r) == S_EXEC))
    else $error("frame walk entered from wrong state");

  a_taken_max: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r <= 7'(scsa_pkg::FRAMES))
    else $error("frames taken beyond frame count");

endmodule
